// ----- sv/lfr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the lockstep frame receiver.
// No dependencies; every module in the project imports this package.
package lfr_pkg;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_VERIFY = 2'd3;

    localparam logic [7:0] KIND_START  = 8'h02;
    localparam logic [7:0] KIND_INPUT  = 8'h03;
    localparam logic [7:0] KIND_HASH   = 8'h04;
    localparam logic [7:0] KIND_BYE    = 8'h05;
    localparam logic [7:0] KIND_DESYNC = 8'h06;

    localparam logic [2:0] MODE_WAITING = 3'd0;
    localparam logic [2:0] MODE_RUNNING = 3'd1;
    localparam logic [2:0] MODE_ENDED   = 3'd2;
    localparam logic [2:0] MODE_DESYNC  = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    // Work decoded from one accepted item, carried down the pipeline.
    typedef struct packed {
        logic        done;
        logic        oversize;
        logic        start;
        logic        bye;
        logic        close;
        logic        desync_req;
        logic        wr_in;
        logic        wr_hash;
        logic        lookup;
        logic        verify;
        logic [30:0] key;
        logic [31:0] tick;
        logic [63:0] data;
        logic [7:0]  held;
        logic [7:0]  pressed;
    } lfr_event_t;

    // Registered read data of both rings for one slot.
    typedef struct packed {
        logic        in_valid;
        logic [30:0] in_tick;
        logic [7:0]  held;
        logic [7:0]  pressed;
        logic        h_valid;
        logic [30:0] h_tick;
        logic [63:0] h_value;
    } lfr_ring_data_t;

endpackage

// ----- sv/lfr_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the lockstep frame receiver: valid/ready plus item fields.
// No dependencies.
interface lfr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [30:0] query_tick;
    logic [63:0] expected_hash;

    modport source (output valid, output cmd, output data_byte, output query_tick,
                    output expected_hash, input ready);
    modport sink (input valid, input cmd, input data_byte, input query_tick,
                  input expected_hash, output ready);
endinterface

// ----- sv/lfr_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the lockstep frame receiver: valid/ready plus result fields.
// No dependencies.
interface lfr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         link_state;
    logic               frame_done;
    logic               found;
    logic [7:0]         held_buttons;
    logic [7:0]         pressed_buttons;
    logic               send_desync;
    logic signed [31:0] divergence_tick;
    logic [63:0]        shared_seed;

    modport source (output valid, output link_state, output frame_done, output found,
                    output held_buttons, output pressed_buttons, output send_desync,
                    output divergence_tick, output shared_seed, input ready);
    modport sink (input valid, input link_state, input frame_done, input found,
                  input held_buttons, input pressed_buttons, input send_desync,
                  input divergence_tick, input shared_seed, output ready);
endinterface

// ----- sv/lfr_parser.sv -----
`timescale 1ns / 1ps
// Byte deframer: length, type and payload capture, decoding each item into an event.
// Depends on lfr_pkg.
module lfr_parser import lfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic [30:0] query_tick,
    input  logic [63:0] expected_hash,
    output lfr_event_t  ev
);

    localparam int CW      = $clog2(MAX_PAYLOAD + 1);
    localparam int CAP_LEN = 12;

    localparam logic [1:0] PH_LEN_LO  = 2'd0;
    localparam logic [1:0] PH_LEN_HI  = 2'd1;
    localparam logic [1:0] PH_KIND    = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]    phase_reg, phase_next;
    logic [15:0]   len_reg, len_next;
    logic [7:0]    kind_reg, kind_next;
    logic [CW-1:0] count_reg, count_next;
    logic          err_reg, err_next;
    logic [7:0]    cap_reg [CAP_LEN];

    logic [7:0]    cap_eff [CAP_LEN];
    logic [CW-1:0] count_inc;
    logic          reached;
    logic          over;
    logic          is_byte;
    logic          dispatch;
    logic [7:0]    kind_eff;
    logic [31:0]   cap_t;
    logic          cap_write;

    always_comb
    begin
        is_byte   = (cmd == CMD_BYTE) && !err_reg;
        cap_write = is_byte && (phase_reg == PH_PAYLOAD);
        for (int i = 0; i < CAP_LEN; i++)
        begin
            cap_eff[i] = (cap_write && (count_reg == CW'(i))) ? data_byte : cap_reg[i];
        end
        cap_t     = {cap_eff[3], cap_eff[2], cap_eff[1], cap_eff[0]};
        count_inc = count_reg + CW'(1);
        reached   = (17'(count_inc) >= {1'b0, len_reg});
        over      = ({1'b0, len_reg} > 17'(MAX_PAYLOAD));
        kind_eff  = (phase_reg == PH_KIND) ? data_byte : kind_reg;
        dispatch  = is_byte && (((phase_reg == PH_KIND) && !over && (len_reg == 16'd0))
                               || ((phase_reg == PH_PAYLOAD) && reached));

        phase_next = phase_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        err_next   = err_reg;
        if (is_byte)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    len_next   = {8'd0, data_byte};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {data_byte, len_reg[7:0]};
                    phase_next = PH_KIND;
                end
                PH_KIND:
                begin
                    kind_next  = data_byte;
                    count_next = '0;
                    if (over)
                    begin
                        err_next   = 1'b1;
                        phase_next = PH_LEN_LO;
                    end
                    else if (len_reg == 16'd0)
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    count_next = count_inc;
                    if (reached)
                    begin
                        count_next = '0;
                        phase_next = PH_LEN_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_LEN_LO;
                end
            endcase
        end

        ev          = '0;
        ev.key      = query_tick;
        ev.tick     = cap_t;
        ev.data     = expected_hash;
        ev.held     = cap_eff[4];
        ev.pressed  = cap_eff[5];
        unique case (cmd)
            CMD_BYTE:
            begin
                ev.done     = dispatch;
                ev.oversize = is_byte && (phase_reg == PH_KIND) && over;
                if (dispatch)
                begin
                    unique case (kind_eff)
                        KIND_START:
                        begin
                            ev.start = (len_reg >= 16'd8);
                            ev.data  = {cap_eff[7], cap_eff[6], cap_eff[5], cap_eff[4],
                                        cap_eff[3], cap_eff[2], cap_eff[1], cap_eff[0]};
                        end
                        KIND_INPUT:
                        begin
                            ev.wr_in = (len_reg >= 16'd6) && !cap_t[31];
                            ev.key   = cap_t[30:0];
                        end
                        KIND_HASH:
                        begin
                            ev.wr_hash = (len_reg >= 16'd12) && !cap_t[31];
                            ev.key     = cap_t[30:0];
                            ev.data    = {cap_eff[11], cap_eff[10], cap_eff[9], cap_eff[8],
                                          cap_eff[7], cap_eff[6], cap_eff[5], cap_eff[4]};
                        end
                        KIND_BYE:    ev.bye        = 1'b1;
                        KIND_DESYNC: ev.desync_req = (len_reg >= 16'd4);
                        default:     ev.done       = 1'b1;
                    endcase
                end
            end
            CMD_CLOSE:  ev.close  = 1'b1;
            CMD_LOOKUP: ev.lookup = 1'b1;
            CMD_VERIFY: ev.verify = 1'b1;
            default:    ev.close  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_LO;
            len_reg   <= '0;
            kind_reg  <= '0;
            count_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < CAP_LEN; i++)
            begin
                cap_reg[i] <= cap_eff[i];
            end
        end
    end

endmodule

// ----- sv/lfr_slot.sv -----
`timescale 1ns / 1ps
// Ring slot of a tick: tick modulo RING_DEPTH by reciprocal multiply and one correction.
// Depends on lfr_pkg; the slot is combinational from the registered key and product.
module lfr_slot import lfr_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    localparam int AW = $clog2(RING_DEPTH)
)
(
    input  logic          clk,
    input  logic          adv,
    input  logic [30:0]   key_in,
    output logic [AW-1:0] slot
);

    localparam logic [27:0] RECIP = 28'((64'd1 << 31) / RING_DEPTH);

    logic [30:0] key_reg;
    logic [58:0] prod_reg;
    logic [27:0] quot;
    logic [40:0] back;
    logic [31:0] rem;
    logic [31:0] rem_fix;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg  <= key_in;
            prod_reg <= {28'd0, key_in} * {31'd0, RECIP};
        end
    end

    // quotient estimate is low by at most one, so one subtract settles it
    always_comb
    begin
        quot    = prod_reg[58:31];
        back    = {13'd0, quot} * 41'(RING_DEPTH);
        rem     = {1'b0, key_reg} - back[31:0];
        rem_fix = (rem >= 32'(RING_DEPTH)) ? rem - 32'(RING_DEPTH) : rem;
        slot    = rem_fix[AW-1:0];
    end

endmodule

// ----- sv/lfr_rings.sv -----
`timescale 1ns / 1ps
// Peer input ring and hash ring, RAMs with registered read, plus the
// clearing sweep after reset. Depends on lfr_pkg.
module lfr_rings import lfr_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    localparam int AW = $clog2(RING_DEPTH)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           req_valid,
    input  lfr_event_t     req,
    input  logic [AW-1:0]  slot,
    output logic           clearing,
    output lfr_ring_data_t rd
);

    logic [47:0] in_mem   [RING_DEPTH];
    logic [95:0] hash_mem [RING_DEPTH];
    logic [47:0] in_q;
    logic [95:0] hash_q;

    logic          clr_reg, clr_next;
    logic [AW-1:0] clr_idx_reg, clr_idx_next;

    logic          we_in, we_hash;
    logic [AW-1:0] waddr;
    logic [47:0]   wdata_in;
    logic [95:0]   wdata_hash;

    always_comb
    begin
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        if (clr_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(RING_DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end

        we_in      = clr_reg || (adv && req_valid && req.wr_in);
        we_hash    = clr_reg || (adv && req_valid && req.wr_hash);
        waddr      = clr_reg ? clr_idx_reg : slot;
        wdata_in   = clr_reg ? '0 : {1'b1, req.key, req.held, req.pressed};
        wdata_hash = clr_reg ? '0 : {1'b1, req.key, req.data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_in)
        begin
            in_mem[waddr] <= wdata_in;
        end
        if (adv)
        begin
            in_q <= in_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_hash)
        begin
            hash_mem[waddr] <= wdata_hash;
        end
        if (adv)
        begin
            hash_q <= hash_mem[slot];
        end
    end

    assign clearing   = clr_reg;
    assign rd.in_valid = in_q[47];
    assign rd.in_tick  = in_q[46:16];
    assign rd.held     = in_q[15:8];
    assign rd.pressed  = in_q[7:0];
    assign rd.h_valid  = hash_q[95];
    assign rd.h_tick   = hash_q[94:64];
    assign rd.h_value  = hash_q[63:0];

endmodule

// ----- sv/lfr_link.sv -----
`timescale 1ns / 1ps
// Link state, seed and divergence tick, lookup/verify resolution and the result register.
// Depends on lfr_pkg and lfr_out_if.
module lfr_link import lfr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ev_valid,
    input  lfr_event_t     ev,
    input  lfr_ring_data_t rd,
    output logic           adv,
    lfr_out_if.source      result
);

    logic [2:0]  mode_reg, mode_next;
    logic [31:0] step_reg, step_next;
    logic [63:0] seed_reg, seed_next;
    logic        out_valid_reg;

    logic        hit;
    logic        vfail;
    logic        sent;
    logic        load;

    logic [2:0]  st_reg;
    logic        done_reg, found_reg, sent_reg;
    logic [7:0]  held_reg, pressed_reg;

    always_comb
    begin
        hit   = ev.lookup && rd.in_valid && (rd.in_tick == ev.key);
        vfail = ev.verify && rd.h_valid && (rd.h_tick == ev.key) && (rd.h_value != ev.data);

        mode_next = mode_reg;
        step_next = step_reg;
        seed_next = seed_reg;
        sent      = 1'b0;
        if (ev.oversize)
        begin
            mode_next = MODE_ERROR;
        end
        if (ev.start)
        begin
            seed_next = ev.data;
            if (mode_reg == MODE_WAITING)
            begin
                mode_next = MODE_RUNNING;
            end
        end
        if ((ev.bye || ev.close) && (mode_reg == MODE_RUNNING || mode_reg == MODE_WAITING))
        begin
            mode_next = MODE_ENDED;
        end
        if ((ev.desync_req || vfail) && mode_reg != MODE_DESYNC && mode_reg != MODE_ERROR)
        begin
            mode_next = MODE_DESYNC;
            step_next = ev.desync_req ? ev.tick : {1'b0, ev.key};
            sent      = 1'b1;
        end
    end

    assign adv  = !out_valid_reg || result.ready;
    assign load = adv && ev_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAITING;
            step_reg      <= '1;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= ev_valid;
            end
            if (load)
            begin
                mode_reg <= mode_next;
                step_reg <= step_next;
                seed_reg <= seed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg      <= mode_next;
            done_reg    <= ev.done;
            found_reg   <= hit;
            held_reg    <= hit ? rd.held : 8'd0;
            pressed_reg <= hit ? rd.pressed : 8'd0;
            sent_reg    <= sent;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.link_state      = st_reg;
    assign result.frame_done      = done_reg;
    assign result.found           = found_reg;
    assign result.held_buttons    = held_reg;
    assign result.pressed_buttons = pressed_reg;
    assign result.send_desync     = sent_reg;
    assign result.divergence_tick = $signed(step_reg);
    assign result.shared_seed     = seed_reg;

endmodule

// ----- sv/lockstep_frame_receiver.sv -----
`timescale 1ns / 1ps
// Lockstep frame receiver top level: deframer, slot unit, rings and link stage.
// Depends on lfr_pkg, lfr_in_if, lfr_out_if and all lfr_* modules.
//
// One item is accepted per cycle while the result register is not stalled and no
// clearing pass runs, and each item gives one result; the pipeline is deframer, slot
// (tick modulo RING_DEPTH by reciprocal multiply), ring RAM access with registered
// read, then link update into the result register. Both rings sit in RAMs touched
// once per item, so lookups, hash checks and ring writes all keep full rate, and a
// stalled result register holds the whole pipe. After reset a clearing pass writes
// every ring slot empty, and no item is accepted until it ends.
module lockstep_frame_receiver import lfr_pkg::*;
#(
    parameter int RING_DEPTH  = 256,
    parameter int MAX_PAYLOAD = 512
)
(
    input  logic      clk,
    input  logic      rst_n,
    lfr_in_if.sink    rx,
    lfr_out_if.source result
);

    localparam int AW = $clog2(RING_DEPTH);

    logic           adv;
    logic           clearing;
    logic           accept;
    lfr_event_t     ev;
    logic [AW-1:0]  slot;
    lfr_ring_data_t rd;

    logic           p1_valid_reg, p2_valid_reg;
    lfr_event_t     p1_ev_reg, p2_ev_reg;

    assign rx.ready = adv && !clearing;
    assign accept   = rx.valid && rx.ready;

    lfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (rx.cmd),
        .data_byte     (rx.data_byte),
        .query_tick    (rx.query_tick),
        .expected_hash (rx.expected_hash),
        .ev            (ev)
    );

    lfr_slot #(
        .RING_DEPTH (RING_DEPTH)
    ) u_slot (
        .clk    (clk),
        .adv    (adv),
        .key_in (ev.key),
        .slot   (slot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ev_reg <= ev;
            p2_ev_reg <= p1_ev_reg;
        end
    end

    lfr_rings #(
        .RING_DEPTH (RING_DEPTH)
    ) u_rings (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (p1_valid_reg),
        .req       (p1_ev_reg),
        .slot      (slot),
        .clearing  (clearing),
        .rd        (rd)
    );

    lfr_link u_link (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (p2_valid_reg),
        .ev       (p2_ev_reg),
        .rd       (rd),
        .adv      (adv),
        .result   (result)
    );

endmodule
